FILE: rtl/vlfr_pkg.sv
// Shared constants, types and the arctangent table of the velocity limiter.
package vlfr_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TRANS_LIMIT = 2'd0;
  localparam logic [1:0] REG_ROT_LIMIT   = 2'd1;
  localparam logic [1:0] REG_PERIOD_DT   = 2'd2;
  localparam logic [1:0] REG_OUTPUT_MODE = 2'd3;

  // output modes (the unused code behaves as field frame)
  localparam logic [1:0] MODE_FIELD = 2'd0;
  localparam logic [1:0] MODE_ROBOT = 2'd1;
  localparam logic [1:0] MODE_ARC   = 2'd2;

  localparam logic [15:0] PERIOD_DT_RESET = 16'd655;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

  localparam int SMALL_ARC = 524288;

  // unit sizes
  localparam int SQRT_IN_W = 48;
  localparam int TDIV_NW   = 40;
  localparam int TDIV_DW   = 24;
  localparam int TDIV_QW   = 17;
  localparam int GDIV_NW   = 49;
  localparam int GDIV_DW   = 31;
  localparam int GDIV_QW   = 32;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] r;
    logic [15:0]        h;
    logic               rcap;
    logic               tcap;
    logic signed [31:0] p;
  } meta_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/vlfr_delay.sv
// Enabled shift line that keeps side data level with the arithmetic units.
module vlfr_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < D; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[D-1];

endmodule

FILE: rtl/vlfr_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module vlfr_sqrt #(
  parameter int IW = 48
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IW-1:0]   d,
  output logic [IW/2-1:0] root
);

  localparam int OW = IW / 2;

  logic [IW-1:0] v_r [OW];
  logic [IW-1:0] r_r [OW];

  for (genvar g = 0; g < OW; g++) begin : g_stage
    logic [IW-1:0] vi, ri, bitv, trial, v_nxt, r_nxt;
    if (g == 0) begin : g_first
      assign vi = d;
      assign ri = '0;
    end else begin : g_next
      assign vi = v_r[g-1];
      assign ri = r_r[g-1];
    end
    assign bitv  = IW'(1) << (IW - 2 - 2 * g);
    assign trial = ri + bitv;
    always_comb begin
      if (vi >= trial) begin
        v_nxt = vi - trial;
        r_nxt = (ri >> 1) + bitv;
      end else begin
        v_nxt = vi;
        r_nxt = ri >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[g] <= v_nxt;
        r_r[g] <= r_nxt;
      end
    end
  end

  assign root = r_r[OW-1][OW-1:0];

endmodule

FILE: rtl/vlfr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module vlfr_div #(
  parameter int NW = 40,
  parameter int DW = 24,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int WW = NW + DW;

  logic [WW-1:0] rem_r [QW];
  logic [DW-1:0] d_r   [QW];
  logic [QW-1:0] q_r   [QW];
  logic          ovf_r [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [WW-1:0] ri, trial, rem_nxt;
    logic [DW-1:0] di;
    logic [QW-1:0] qi, q_nxt;
    logic          oi;
    if (g == 0) begin : g_first
      assign ri = WW'(num);
      assign di = den;
      assign qi = '0;
      // quotient too wide for QW bits
      assign oi = WW'(num) >= (WW'(den) << QW);
    end else begin : g_next
      assign ri = rem_r[g-1];
      assign di = d_r[g-1];
      assign qi = q_r[g-1];
      assign oi = ovf_r[g-1];
    end
    assign trial = WW'(di) << (QW - 1 - g);
    always_comb begin
      if (ri >= trial) begin
        rem_nxt = ri - trial;
        q_nxt   = qi | (QW'(1) << (QW - 1 - g));
      end else begin
        rem_nxt = ri;
        q_nxt   = qi;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        d_r[g]   <= di;
        q_r[g]   <= q_nxt;
        ovf_r[g] <= oi;
      end
    end
  end

  assign quo = q_r[QW-1];
  assign ovf = ovf_r[QW-1];

endmodule

FILE: rtl/vlfr_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q1.30.
module vlfr_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        angle,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int N = vlfr_pkg::CORDIC_STEPS;
  localparam int W = vlfr_pkg::CORDIC_W;

  logic signed [W-1:0] x_r [N];
  logic signed [W-1:0] y_r [N];
  logic signed [W-1:0] z_r [N];
  logic                flip_r [N];

  // second and third quadrants are turned by pi first
  logic        flip_in;
  logic [31:0] a_in;
  assign flip_in = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
  assign a_in    = flip_in ? angle + 32'h8000_0000 : angle;

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic signed [W-1:0] xi, yi, zi, xs, ys, at, x_nxt, y_nxt, z_nxt;
    logic                fi;
    if (g == 0) begin : g_first
      assign xi = vlfr_pkg::CORDIC_START;
      assign yi = '0;
      assign zi = W'($signed(a_in));
      assign fi = flip_in;
    end else begin : g_next
      assign xi = x_r[g-1];
      assign yi = y_r[g-1];
      assign zi = z_r[g-1];
      assign fi = flip_r[g-1];
    end
    assign xs = xi >>> g;
    assign ys = yi >>> g;
    assign at = $signed(W'(vlfr_pkg::atan_entry(5'(g))));
    always_comb begin
      if (!zi[W-1]) begin
        x_nxt = xi - ys;
        y_nxt = yi + xs;
        z_nxt = zi - at;
      end else begin
        x_nxt = xi + ys;
        y_nxt = yi - xs;
        z_nxt = zi + at;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g]    <= x_nxt;
        y_r[g]    <= y_nxt;
        z_r[g]    <= z_nxt;
        flip_r[g] <= fi;
      end
    end
  end

  logic signed [W-1:0] xf, yf;
  assign xf = flip_r[N-1] ? -x_r[N-1] : x_r[N-1];
  assign yf = flip_r[N-1] ? -y_r[N-1] : y_r[N-1];
  assign cos_o = xf[31:0];
  assign sin_o = yf[31:0];

endmodule

FILE: rtl/velocity_limit_frame_rotate_core.sv
// Velocity limiter with field, robot and arc-compensated robot frame output.
// Takes one item per cycle while no stalled result holds the pipeline.
// The depth is set by the chain half-angle CORDIC (30), gain divider (32) and
// the final multiply stages; the translation square root and divider run alongside.
// A stalled result freezes the whole pipeline; in_ready is high unless a valid result is stalled.
// Reset (synchronous, rst_n low) empties the pipeline and restores the registers.
module velocity_limit_frame_rotate_core (
  input  logic               clk,
  input  logic               rst_n,
  // command input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_cmd_vel_x,
  input  logic signed [15:0] in_cmd_vel_y,
  input  logic signed [15:0] in_cmd_vel_rot,
  input  logic signed [15:0] in_heading,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_vel_x,
  output logic signed [15:0] out_vel_y,
  output logic signed [15:0] out_vel_rot,
  output logic               out_trans_capped,
  output logic               out_rot_capped,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // pipeline levels: a value "at level k" leaves the k-th register layer
  localparam int L_SQ   = 2;
  localparam int L_N    = L_SQ + vlfr_pkg::SQRT_IN_W / 2;
  localparam int L_TNUM = L_N + 1;
  localparam int L_TQ   = L_TNUM + vlfr_pkg::TDIV_QW;
  localparam int L_TX   = L_TQ + 1;
  localparam int L_B    = 4;
  localparam int L_SB   = L_B + vlfr_pkg::CORDIC_STEPS;
  localparam int L_GIN  = L_SB + 1;
  localparam int L_C2   = L_GIN + vlfr_pkg::CORDIC_STEPS;
  localparam int L_GQ   = L_GIN + vlfr_pkg::GDIV_QW;
  localparam int L_GU   = L_GQ + 3;
  localparam int L_OUT  = L_GU + 1;

  // ---------------------------------------------------------------- config
  logic [14:0] tl_r, rl_r;
  logic [15:0] dt_r;
  logic [1:0]  mode_r;
  logic [29:0] ltsq_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r   <= '0;
      rl_r   <= '0;
      dt_r   <= vlfr_pkg::PERIOD_DT_RESET;
      mode_r <= vlfr_pkg::MODE_FIELD;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        vlfr_pkg::REG_TRANS_LIMIT: tl_r   <= pwdata[14:0];
        vlfr_pkg::REG_ROT_LIMIT:   rl_r   <= pwdata[14:0];
        vlfr_pkg::REG_PERIOD_DT:   dt_r   <= pwdata[15:0];
        vlfr_pkg::REG_OUTPUT_MODE: mode_r <= pwdata[1:0];
      endcase
    end
  end

  // square of the cap, settles the cycle after a write; user keeps block idle then, unenforced
  always_ff @(posedge clk) ltsq_r <= 30'(tl_r * tl_r);

  always_comb begin
    unique case (paddr[3:2])
      vlfr_pkg::REG_TRANS_LIMIT: prdata = {17'd0, tl_r};
      vlfr_pkg::REG_ROT_LIMIT:   prdata = {17'd0, rl_r};
      vlfr_pkg::REG_PERIOD_DT:   prdata = {16'd0, dt_r};
      vlfr_pkg::REG_OUTPUT_MODE: prdata = {30'd0, mode_r};
    endcase
  end

  // -------------------------------------------------------- flow control
  logic               en;
  logic [L_OUT:1]     vld_r;

  assign out_valid = vld_r[L_OUT];
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[L_OUT-1:1], in_valid};
  end

  // ------------------------------------------------- level 1: rotation cap
  logic [15:0]        r_abs;
  logic               rcap_c;
  logic signed [15:0] rl_s, r_c;
  logic signed [31:0] xx_c, yy_c;

  assign rl_s   = $signed({1'b0, rl_r});
  assign r_abs  = in_cmd_vel_rot[15] ? 16'(-in_cmd_vel_rot) : in_cmd_vel_rot;
  assign rcap_c = (rl_r != '0) && (r_abs >= {1'b0, rl_r});
  assign r_c    = rcap_c ? (in_cmd_vel_rot[15] ? -rl_s : rl_s) : in_cmd_vel_rot;
  assign xx_c   = in_cmd_vel_x * in_cmd_vel_x;
  assign yy_c   = in_cmd_vel_y * in_cmd_vel_y;

  logic signed [15:0] x1_r, y1_r, r1_r;
  logic [15:0]        h1_r;
  logic               rcap1_r;
  logic [30:0]        xx1_r, yy1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= in_cmd_vel_x;
      y1_r    <= in_cmd_vel_y;
      r1_r    <= r_c;
      h1_r    <= in_heading;
      rcap1_r <= rcap_c;
      xx1_r   <= xx_c[30:0];
      yy1_r   <= yy_c[30:0];
    end
  end

  // ------------------------------- level 2: length test and arc product p
  logic [31:0]        sq_c;
  logic signed [32:0] p_c;
  vlfr_pkg::meta_t    m2_c, m2_r;
  logic [31:0]        sq2_r;

  assign sq_c = {1'b0, xx1_r} + {1'b0, yy1_r};
  assign p_c  = r1_r * $signed({1'b0, dt_r});

  always_comb begin
    m2_c.x    = x1_r;
    m2_c.y    = y1_r;
    m2_c.r    = r1_r;
    m2_c.h    = h1_r;
    m2_c.rcap = rcap1_r;
    // cap acts at or above the limit
    m2_c.tcap = (tl_r != '0) && (sq_c >= {2'b00, ltsq_r});
    m2_c.p    = p_c[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r  <= m2_c;
      sq2_r <= sq_c;
    end
  end

  // side data travelling with the units
  vlfr_pkg::meta_t m26, m34, m44, m70;

  vlfr_delay #(.W($bits(vlfr_pkg::meta_t)), .D(L_N - L_SQ)) u_dly_m26 (
    .clk(clk), .en(en), .d(m2_r), .q(m26));
  vlfr_delay #(.W($bits(vlfr_pkg::meta_t)), .D(L_SB - L_N)) u_dly_m34 (
    .clk(clk), .en(en), .d(m26), .q(m34));
  vlfr_delay #(.W($bits(vlfr_pkg::meta_t)), .D(L_TQ - L_SB)) u_dly_m44 (
    .clk(clk), .en(en), .d(m34), .q(m44));
  vlfr_delay #(.W($bits(vlfr_pkg::meta_t)), .D(L_GU - L_TQ)) u_dly_m70 (
    .clk(clk), .en(en), .d(m44), .q(m70));

  // -------------------------------------------------- translation branch
  logic [23:0] n26;

  vlfr_sqrt #(.IW(vlfr_pkg::SQRT_IN_W)) u_sqrt (
    .clk(clk), .en(en), .d({sq2_r, 16'd0}), .root(n26));

  // level 27: scaled numerators with half-divisor rounding
  logic [15:0] ax_c, ay_c;
  logic [30:0] px_c, py_c;
  logic [vlfr_pkg::TDIV_NW-1:0] numx27_r, numy27_r;
  logic [vlfr_pkg::TDIV_DW-1:0] dt27_r;
  logic [1:0]                   neg27_r, neg44;

  assign ax_c = m26.x[15] ? 16'(-m26.x) : m26.x;
  assign ay_c = m26.y[15] ? 16'(-m26.y) : m26.y;
  assign px_c = ax_c * tl_r;
  assign py_c = ay_c * tl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      numx27_r <= 40'({px_c, 8'd0}) + 40'(n26[23:1]);
      numy27_r <= 40'({py_c, 8'd0}) + 40'(n26[23:1]);
      dt27_r   <= m26.tcap ? n26 : 24'd1;
      neg27_r  <= {m26.x[15], m26.y[15]};
    end
  end

  logic [vlfr_pkg::TDIV_QW-1:0] qx44, qy44;
  logic                         ovfx44, ovfy44;

  vlfr_div #(.NW(vlfr_pkg::TDIV_NW), .DW(vlfr_pkg::TDIV_DW), .QW(vlfr_pkg::TDIV_QW)) u_div_x (
    .clk(clk), .en(en), .num(numx27_r), .den(dt27_r), .quo(qx44), .ovf(ovfx44));
  vlfr_div #(.NW(vlfr_pkg::TDIV_NW), .DW(vlfr_pkg::TDIV_DW), .QW(vlfr_pkg::TDIV_QW)) u_div_y (
    .clk(clk), .en(en), .num(numy27_r), .den(dt27_r), .quo(qy44), .ovf(ovfy44));

  vlfr_delay #(.W(2), .D(L_TQ - L_TNUM)) u_dly_neg (
    .clk(clk), .en(en), .d(neg27_r), .q(neg44));

  // signed, saturated result of a magnitude quotient
  function automatic logic signed [15:0] cap_sat(input logic neg, input logic [16:0] q,
                                                 input logic ovf);
    logic signed [17:0] nq;
    nq = -$signed({1'b0, q});
    if (ovf)              return neg ? 16'sh8000 : 16'sh7FFF;
    else if (neg)         return (q > 17'd32768) ? 16'sh8000 : nq[15:0];
    else                  return (q > 17'd32767) ? 16'sh7FFF : $signed(q[15:0]);
  endfunction

  // level 45: limited field-frame components
  logic signed [15:0] tx45_r, ty45_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tx45_r <= m44.tcap ? cap_sat(neg44[1], qx44, ovfx44) : m44.x;
      ty45_r <= m44.tcap ? cap_sat(neg44[0], qy44, ovfy44) : m44.y;
    end
  end

  logic [31:0] txy67;

  vlfr_delay #(.W(32), .D(L_GQ - L_TX)) u_dly_txy (
    .clk(clk), .en(en), .d({tx45_r, ty45_r}), .q(txy67));

  // ---------------------------------------------------------- arc branch
  // level 3: p times 4/pi in Q20
  logic signed [53:0] pk3_r, t20_c;
  logic signed [31:0] p3_r;
  logic [31:0]        ap3_c;

  always_ff @(posedge clk) begin
    if (en) begin
      pk3_r <= m2_r.p * 22'sd1335088;
      p3_r  <= m2_r.p;
    end
  end

  // level 4: half angle b, rounded half away from zero
  assign t20_c = pk3_r[53] ? -((-pk3_r + 54'sd524288) >>> 20)
                           : (pk3_r + 54'sd524288) >>> 20;
  assign ap3_c = p3_r[31] ? 32'(-p3_r) : p3_r;

  logic [32:0] bs4_r, bs34;

  always_ff @(posedge clk) begin
    if (en) bs4_r <= {t20_c[31:0], (ap3_c < 32'(vlfr_pkg::SMALL_ARC))};
  end

  logic signed [31:0] sb34;

  vlfr_cordic u_cordic_b (
    .clk(clk), .en(en), .angle(bs4_r[32:1]), .cos_o(), .sin_o(sb34));

  vlfr_delay #(.W(33), .D(L_SB - L_B)) u_dly_b (
    .clk(clk), .en(en), .d(bs4_r), .q(bs34));

  // level 35: singular test, rotation angle and gain division operands
  logic        small34, sing_c, arc_c, useg_c;
  logic [31:0] b34, h32_c, ap34_c, asb_c;

  assign b34     = bs34[32:1];
  assign small34 = bs34[0];
  assign h32_c   = {m34.h, 16'd0};
  assign arc_c   = (mode_r == vlfr_pkg::MODE_ARC);
  assign sing_c  = !small34 && ((b34[30:0] == '0) || (sb34 == '0));
  assign useg_c  = arc_c && !small34 && !sing_c;
  assign ap34_c  = m34.p[31] ? 32'(-m34.p) : m34.p;
  assign asb_c   = sb34[31] ? 32'(-sb34) : sb34;

  logic [31:0]                  ang35_r;
  logic [vlfr_pkg::GDIV_NW-1:0] numg35_r;
  logic [vlfr_pkg::GDIV_DW-1:0] dg35_r;
  logic [1:0]                   gf35_r, gf67;

  always_ff @(posedge clk) begin
    if (en) begin
      // a singular arc falls back to the plain heading rotation
      ang35_r  <= (arc_c && !sing_c) ? h32_c + b34 : h32_c;
      numg35_r <= 49'({ap34_c, 17'd0}) + 49'(asb_c[31:1]);
      dg35_r   <= useg_c ? asb_c[30:0] : 31'd1;
      gf35_r   <= {useg_c, m34.p[31] ^ sb34[31]};
    end
  end

  logic signed [31:0] c65, s65;
  logic [63:0]        cs67;

  vlfr_cordic u_cordic_rot (
    .clk(clk), .en(en), .angle(ang35_r), .cos_o(c65), .sin_o(s65));

  vlfr_delay #(.W(64), .D(L_GQ - L_C2)) u_dly_cs (
    .clk(clk), .en(en), .d({c65, s65}), .q(cs67));

  logic [vlfr_pkg::GDIV_QW-1:0] qg67;
  logic                         ovfg67;

  vlfr_div #(.NW(vlfr_pkg::GDIV_NW), .DW(vlfr_pkg::GDIV_DW), .QW(vlfr_pkg::GDIV_QW)) u_div_g (
    .clk(clk), .en(en), .num(numg35_r), .den(dg35_r), .quo(qg67), .ovf(ovfg67));

  vlfr_delay #(.W(2), .D(L_GQ - L_GIN)) u_dly_gf (
    .clk(clk), .en(en), .d(gf35_r), .q(gf67));

  // ------------------------------------------------------ frame rotation
  // level 68: gain with saturation at 2^31, and the four products
  logic signed [31:0] c67, s67;
  logic signed [15:0] tx67, ty67;
  logic [32:0]        gmag_c;
  logic signed [32:0] g_c;

  assign c67    = cs67[63:32];
  assign s67    = cs67[31:0];
  assign tx67   = txy67[31:16];
  assign ty67   = txy67[15:0];
  assign gmag_c = (ovfg67 || (qg67 > 32'h8000_0000)) ? 33'h0_8000_0000 : {1'b0, qg67};
  assign g_c    = gf67[1] ? (gf67[0] ? -$signed(gmag_c) : $signed(gmag_c)) : 33'sd65536;

  logic signed [32:0] g68_r, g69_r;
  logic signed [47:0] cx68_r, sy68_r, cy68_r, sx68_r;
  logic signed [15:0] tx68_r, ty68_r, tx69_r, ty69_r, tx70_r, ty70_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g68_r  <= g_c;
      cx68_r <= c67 * tx67;
      sy68_r <= s67 * ty67;
      cy68_r <= c67 * ty67;
      sx68_r <= s67 * tx67;
      tx68_r <= tx67;
      ty68_r <= ty67;
    end
  end

  function automatic logic signed [26:0] rnd22(input logic signed [48:0] v);
    logic signed [48:0] t;
    t = v[48] ? -((-v + 49'sd2097152) >>> 22) : (v + 49'sd2097152) >>> 22;
    return t[26:0];
  endfunction

  function automatic logic signed [35:0] rnd24(input logic signed [59:0] v);
    logic signed [59:0] t;
    t = v[59] ? -((-v + 60'sd8388608) >>> 24) : (v + 60'sd8388608) >>> 24;
    return t[35:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767)       return 16'sh7FFF;
    else if (v < -36'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  // level 69: rotated components in Q8
  logic signed [26:0] u69_r, v69_r;

  always_ff @(posedge clk) begin
    if (en) begin
      u69_r  <= rnd22(49'(cx68_r) + 49'(sy68_r));
      v69_r  <= rnd22(49'(cy68_r) - 49'(sx68_r));
      g69_r  <= g68_r;
      tx69_r <= tx68_r;
      ty69_r <= ty68_r;
    end
  end

  // level 70: arc gain
  logic signed [59:0] gu70_r, gv70_r;

  always_ff @(posedge clk) begin
    if (en) begin
      gu70_r <= g69_r * u69_r;
      gv70_r <= g69_r * v69_r;
      tx70_r <= tx69_r;
      ty70_r <= ty69_r;
    end
  end

  // level 71: output register, frame select
  logic rot_sel;
  assign rot_sel = (mode_r == vlfr_pkg::MODE_ROBOT) || (mode_r == vlfr_pkg::MODE_ARC);

  always_ff @(posedge clk) begin
    if (en) begin
      out_vel_x        <= rot_sel ? sat16(rnd24(gu70_r)) : tx70_r;
      out_vel_y        <= rot_sel ? sat16(rnd24(gv70_r)) : ty70_r;
      out_vel_rot      <= m70.r;
      out_trans_capped <= m70.tcap;
      out_rot_capped   <= m70.rcap;
    end
  end

`ifndef SYNTH
  // a translation cap never shows without a nonzero limit
  a_tcap_needs_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trans_capped |-> tl_r != '0)
    else $error("translation cap flagged with limit off");

  // a capped rotation sits exactly at plus or minus the limit
  a_rcap_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rot_capped |->
      (out_vel_rot == $signed({1'b0, rl_r})) || (out_vel_rot == -$signed({1'b0, rl_r})))
    else $error("capped rotation not at limit");

  // a stalled result freezes the pipeline, so no item enters behind it
  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> vld_r == $past(vld_r))
    else $error("pipeline moved under a stalled result");
`endif

endmodule
